### hdl/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared widths, reset values, register indexes and types for the cruise
// throttle controller.
// ----------------------------------------------------------------------------
package ctc_pkg;

    // field widths
    localparam int SPEED_W    = 11;
    localparam int THROTTLE_W = 8;
    localparam int TARGET_W   = 7;
    localparam int ENGAGE_W   = 10;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;

    // register reset values
    localparam logic [THROTTLE_W-1:0] THROTTLE_LIMIT_RST = 8'd80;
    localparam logic [ENGAGE_W-1:0]   ENGAGE_SPEED_RST   = 10'd200;
    localparam logic [THROTTLE_W-1:0] PEDAL_STEP_RST     = 8'd5;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THROTTLE_LIMIT = 2'd0,
        CFG_ENGAGE_SPEED   = 2'd1,
        CFG_PEDAL_STEP     = 2'd2
    } ctc_cfg_idx_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [THROTTLE_W-1:0] throttle_limit;
        logic [ENGAGE_W-1:0]   engage_speed;
        logic [THROTTLE_W-1:0] pedal_step;
    } ctc_cfg_t;

    // controller state, also the result payload minus engine_running
    typedef struct packed {
        logic [THROTTLE_W-1:0] throttle;
        logic                  engaged;
        logic [TARGET_W-1:0]   target;
    } ctc_state_t;

    // one control period
    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic                      engine_switch;
        logic                      top_gear_switch;
        logic                      gas_button;
        logic                      brake_button;
        logic                      cruise_button;
    } ctc_item_t;

endpackage

### hdl/ctc_in_if.sv
// ----------------------------------------------------------------------------
// ctc_in_if
// Input channel: one control period per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ctc_in_if;
    import ctc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] speed;
    logic                      engine_switch;
    logic                      top_gear_switch;
    logic                      gas_button;
    logic                      brake_button;
    logic                      cruise_button;

    modport source (
        output valid, speed, engine_switch, top_gear_switch,
               gas_button, brake_button, cruise_button,
        input  ready
    );

    modport sink (
        input  valid, speed, engine_switch, top_gear_switch,
               gas_button, brake_button, cruise_button,
        output ready
    );
endinterface

### hdl/ctc_out_if.sv
// ----------------------------------------------------------------------------
// ctc_out_if
// Result channel: throttle and cruise status per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ctc_out_if;
    import ctc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [THROTTLE_W-1:0] throttle_out;
    logic                  cruise_on;
    logic [TARGET_W-1:0]   target_out;
    logic                  engine_running;

    modport source (
        output valid, throttle_out, cruise_on, target_out, engine_running,
        input  ready
    );

    modport sink (
        input  valid, throttle_out, cruise_on, target_out, engine_running,
        output ready
    );
endinterface

### hdl/ctc_step.sv
// ----------------------------------------------------------------------------
// ctc_step
// Next-state logic for one control period: pedals, cruise engage/disengage
// and cruise throttle trim.
// ----------------------------------------------------------------------------
module ctc_step (
    input  ctc_pkg::ctc_cfg_t   cfg,
    input  ctc_pkg::ctc_state_t state,
    input  ctc_pkg::ctc_item_t  item,
    output ctc_pkg::ctc_state_t state_next,
    output logic                running
);
    import ctc_pkg::*;

    // x/10 == (x*205) >> 11 for every x below 1029
    localparam int          DIV10_SHIFT = 11;
    localparam logic [7:0]  DIV10_MUL   = 8'd205;
    localparam int          PROD_W      = ENGAGE_W + 8;
    localparam int          ERR_W       = SPEED_W + 2;

    // trim thresholds and steps
    localparam logic signed [ERR_W-1:0] ERR_BIG   = 13'sd20;
    localparam logic signed [ERR_W-1:0] ERR_MID   = 13'sd10;
    localparam logic signed [ERR_W-1:0] ERR_SMALL = 13'sd4;
    localparam logic [THROTTLE_W-1:0]   TRIM_BIG   = 8'd10;
    localparam logic [THROTTLE_W-1:0]   TRIM_MID   = 8'd5;
    localparam logic [THROTTLE_W-1:0]   TRIM_SMALL = 8'd1;

    // increase that saturates at the limit
    function automatic logic [THROTTLE_W-1:0] sat_add(
        input logic [THROTTLE_W-1:0] t,
        input logic [THROTTLE_W-1:0] n,
        input logic [THROTTLE_W-1:0] lim
    );
        logic [THROTTLE_W:0] s;
        s = {1'b0, t} + {1'b0, n};
        return (s > {1'b0, lim}) ? lim : s[THROTTLE_W-1:0];
    endfunction

    // decrease floored at zero
    function automatic logic [THROTTLE_W-1:0] floor_sub(
        input logic [THROTTLE_W-1:0] t,
        input logic [THROTTLE_W-1:0] n
    );
        return (t <= n) ? '0 : t - n;
    endfunction

    logic                        speed_zero;
    logic signed [SPEED_W:0]     speed_ext;
    logic signed [SPEED_W:0]     engage_ext;
    logic                        engage_ok;
    logic [PROD_W-1:0]           div_prod;
    logic [TARGET_W-1:0]         target_new;
    logic [SPEED_W-1:0]          target_x10;
    logic signed [ERR_W-1:0]     err;
    logic [THROTTLE_W-1:0]       thr_gas;
    logic [THROTTLE_W-1:0]       thr_brake;
    logic                        engaged_set;
    logic [TARGET_W-1:0]         target_set;
    logic                        disengage;

    assign speed_zero = (item.speed == '0);
    assign running    = item.engine_switch || !speed_zero;

    // engage check, signed speed against unsigned register
    assign speed_ext  = {item.speed[SPEED_W-1], item.speed};
    assign engage_ext = signed'({2'b00, cfg.engage_speed});
    assign engage_ok  = item.cruise_button && (speed_ext >= engage_ext);

    // target = speed/10; speed is non-negative whenever it is used
    assign div_prod   = PROD_W'(item.speed[ENGAGE_W-1:0]) * PROD_W'(DIV10_MUL);
    assign target_new = div_prod[DIV10_SHIFT +: TARGET_W];

    // pedals
    assign thr_gas   = item.gas_button
                     ? sat_add(state.throttle, cfg.pedal_step, cfg.throttle_limit)
                     : state.throttle;
    assign thr_brake = !item.brake_button ? thr_gas
                     : speed_zero         ? '0
                     : floor_sub(thr_gas, cfg.pedal_step);

    // engage, then disengage
    assign engaged_set = engage_ok || state.engaged;
    assign target_set  = (engage_ok && !state.engaged) ? target_new : state.target;
    assign disengage   = item.gas_button || item.brake_button || !item.top_gear_switch;

    // speed error against the latched target, including one latched this period
    assign target_x10 = {1'b0, target_set, 3'b000} + {3'b000, target_set, 1'b0};
    assign err        = {{2{item.speed[SPEED_W-1]}}, item.speed}
                      - signed'({2'b00, target_x10});

    always_comb
    begin
        state_next = state;
        if (running)
        begin
            state_next.throttle = thr_brake;
            state_next.engaged  = disengage ? 1'b0 : engaged_set;
            state_next.target   = disengage ? '0   : target_set;
            // cruise trim
            if (engaged_set && !disengage)
            begin
                if (err >= ERR_BIG)
                    state_next.throttle = floor_sub(thr_brake, TRIM_BIG);
                else if (err >= ERR_MID)
                    state_next.throttle = floor_sub(thr_brake, TRIM_MID);
                else if (err >= ERR_SMALL)
                    state_next.throttle = floor_sub(thr_brake, TRIM_SMALL);
                else if (err <= -ERR_BIG)
                    state_next.throttle = sat_add(thr_brake, TRIM_BIG,
                                                  cfg.throttle_limit);
                else if (err <= -ERR_MID)
                    state_next.throttle = sat_add(thr_brake, TRIM_MID,
                                                  cfg.throttle_limit);
                else if (err <= -ERR_SMALL)
                    state_next.throttle = sat_add(thr_brake, TRIM_SMALL,
                                                  cfg.throttle_limit);
            end
        end
    end

endmodule

### hdl/cruise_throttle_controller.sv
// ----------------------------------------------------------------------------
// cruise_throttle_controller
// Throttle and cruise-control decision logic, one item per control period.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item goes into the input register, then through the
//   next-state logic into the result register.
// Throughput: one item per cycle; the state feedback through ctc_step is
//   combinational into state_reg, and the result register stalls only on out_ch.ready.
// Reset: rst_n clears throttle, cruise flag, target and both valid flags and
//   loads the register defaults (limit 80, engage speed 200, pedal step 5).
module cruise_throttle_controller (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ctc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ctc_pkg::CFG_DATA_W-1:0]     cfg_data,
    ctc_in_if.sink                             in_ch,
    ctc_out_if.source                          out_ch
);
    import ctc_pkg::*;

    ctc_cfg_t   cfg_reg;
    ctc_state_t state_reg;
    ctc_state_t state_next;
    ctc_item_t  item_reg;
    logic       item_valid_reg;
    logic       res_valid_reg;
    ctc_state_t res_reg;
    logic       res_running_reg;
    logic       running;
    logic       res_ready;
    logic       in_fire;
    logic       step_fire;

    // handshake
    assign res_ready   = !res_valid_reg || out_ch.ready;
    assign in_ch.ready = !item_valid_reg || res_ready;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign step_fire   = item_valid_reg && res_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.throttle_limit <= THROTTLE_LIMIT_RST;
            cfg_reg.engage_speed   <= ENGAGE_SPEED_RST;
            cfg_reg.pedal_step     <= PEDAL_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THROTTLE_LIMIT: cfg_reg.throttle_limit <= cfg_data[THROTTLE_W-1:0];
                CFG_ENGAGE_SPEED:   cfg_reg.engage_speed   <= cfg_data[ENGAGE_W-1:0];
                CFG_PEDAL_STEP:     cfg_reg.pedal_step     <= cfg_data[THROTTLE_W-1:0];
                default:            ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ch.ready)
            item_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.speed           <= in_ch.speed;
            item_reg.engine_switch   <= in_ch.engine_switch;
            item_reg.top_gear_switch <= in_ch.top_gear_switch;
            item_reg.gas_button      <= in_ch.gas_button;
            item_reg.brake_button    <= in_ch.brake_button;
            item_reg.cruise_button   <= in_ch.cruise_button;
        end
    end

    // next-state logic
    ctc_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .running    (running)
    );

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (step_fire)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_ready)
            res_valid_reg <= item_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            res_reg         <= state_next;
            res_running_reg <= running;
        end
    end

    assign out_ch.valid          = res_valid_reg;
    assign out_ch.throttle_out   = res_reg.throttle;
    assign out_ch.cruise_on      = res_reg.engaged;
    assign out_ch.target_out     = res_reg.target;
    assign out_ch.engine_running = res_running_reg;

    // a cleared cruise flag always comes with a cleared target
    a_target_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.engaged |-> (state_reg.target == '0))
        else $error("target held while cruise is off");

    // a latched target comes from a speed of at most 1023
    a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.target <= 7'd102)
        else $error("target out of range");

    // engine off and standing leaves the state untouched
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && !running) |=> (state_reg == $past(state_reg)))
        else $error("state changed with engine off");

    // any net increase of the throttle ends at or below the limit
    a_increase_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && (state_next.throttle > state_reg.throttle))
        |-> (state_next.throttle <= cfg_reg.throttle_limit))
        else $error("throttle increase past limit");

    // a result taken with nothing in the input stage leaves the output empty
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && out_ch.ready && !item_valid_reg) |=> !res_valid_reg)
        else $error("result repeated");

endmodule
